// ===== rtl/mfrf_pkg.sv =====
`default_nettype none

package mfrf_pkg;

    // Geometry of the frame store.
    localparam int FRAMES       = 1024;
    localparam int MAX_CHANNELS = 8;
    localparam int PTR_W        = $clog2(FRAMES);

    // Fixed field widths of the ports.
    localparam int SAMPLE_W = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 10;
    localparam int CHAN_W   = 4;

    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;

    // One frame slot: all channel words side by side.
    typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/mfrf_ctrl.sv =====
`default_nettype none

module mfrf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output mfrf_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 done
);

    mfrf_pkg::state_t state_reg;
    mfrf_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfrf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands: capture, execute, then present the result.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.respond = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            mfrf_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mfrf_pkg::ST_EXEC;
                end
            end
            mfrf_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = mfrf_pkg::ST_RESP;
            end
            mfrf_pkg::ST_RESP:
            begin
                cmd.respond = 1'b1;
                done        = 1'b1;
                state_next  = mfrf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mfrf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mfrf_datapath.sv =====
`default_nettype none

module mfrf_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mfrf_pkg::cmd_t                    cmd,
    input  wire logic [mfrf_pkg::FUNC_W-1:0]       func,
    input  wire mfrf_pkg::frame_t                  in_frame,
    input  wire logic                              end_of_call,
    input  wire logic                              cfg_write_en,
    input  wire logic [mfrf_pkg::CHAN_W-1:0]       cfg_write_data,
    output mfrf_pkg::frame_t                       out_frame,
    output logic [mfrf_pkg::STATUS_W-1:0]          status,
    output logic [mfrf_pkg::FILL_W-1:0]            fill_frames,
    output logic                                   last_of_call
);

    localparam logic [mfrf_pkg::PTR_W-1:0] PTR_LAST   = mfrf_pkg::PTR_W'(mfrf_pkg::FRAMES - 1);
    localparam logic [mfrf_pkg::PTR_W:0]   FRAMES_EXT = (mfrf_pkg::PTR_W+1)'(mfrf_pkg::FRAMES);

    // Frame store, one full frame per row.
    mfrf_pkg::frame_t mem [mfrf_pkg::FRAMES];

    // Captured transaction.
    logic [mfrf_pkg::FUNC_W-1:0]   func_reg;
    mfrf_pkg::frame_t              wr_data_reg;
    logic                          last_reg;

    // Pointers, configuration and result registers.
    logic [mfrf_pkg::PTR_W-1:0]    wp_reg;
    logic [mfrf_pkg::PTR_W-1:0]    wp_next;
    logic [mfrf_pkg::PTR_W-1:0]    rp_reg;
    logic [mfrf_pkg::PTR_W-1:0]    rp_next;
    logic [mfrf_pkg::CHAN_W-1:0]   cc_reg;
    logic [mfrf_pkg::STATUS_W-1:0] status_reg;
    logic [mfrf_pkg::STATUS_W-1:0] status_next;
    logic                          rd_ok_reg;
    logic                          rd_ok_next;
    mfrf_pkg::frame_t              rd_data_reg;

    logic [mfrf_pkg::PTR_W-1:0]    fill;
    logic                          full;
    logic                          empty;
    logic                          mem_we;
    logic                          mem_re;

    // Occupancy from the two pointers; one slot always stays empty.
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            fill = wp_reg - rp_reg;
        end
        else
        begin
            fill = mfrf_pkg::PTR_W'({1'b0, wp_reg} + FRAMES_EXT - {1'b0, rp_reg});
        end
    end

    assign full  = (fill == PTR_LAST);
    assign empty = (wp_reg == rp_reg);

    // Capture the operands of an accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func;
            wr_data_reg <= in_frame;
            last_reg    <= end_of_call;
        end
    end

    // Decode the operation and work out pointer updates.
    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        status_next = mfrf_pkg::STATUS_DONE;
        rd_ok_next  = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (func_reg)
            mfrf_pkg::FUNC_WRITE:
            begin
                if (full)
                begin
                    status_next = mfrf_pkg::STATUS_FULL;
                end
                else
                begin
                    mem_we  = cmd.exec;
                    wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                end
            end
            mfrf_pkg::FUNC_READ:
            begin
                if (empty)
                begin
                    status_next = mfrf_pkg::STATUS_UNDER;
                end
                else
                begin
                    mem_re     = cmd.exec;
                    rd_ok_next = 1'b1;
                    rp_next    = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                end
            end
            mfrf_pkg::FUNC_CLEAR:
            begin
                wp_next = '0;
                rp_next = '0;
            end
            default:
            begin
                status_next = mfrf_pkg::STATUS_DONE;
            end
        endcase
    end

    // Control state: pointers, live channel count and read flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            cc_reg    <= mfrf_pkg::CHAN_RESET;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cc_reg <= cfg_write_data;
            end
            if (cmd.exec)
            begin
                wp_reg    <= wp_next;
                rp_reg    <= rp_next;
                rd_ok_reg <= rd_ok_next;
            end
        end
    end

    // Result status.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
        end
    end

    // Frame store: one row written or read per transaction, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= wr_data_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    // Show only the live channels of a successful read.
    always_comb
    begin
        for (int k = 0; k < mfrf_pkg::MAX_CHANNELS; k++)
        begin
            if (rd_ok_reg && (k < int'(cc_reg)))
            begin
                out_frame[k] = rd_data_reg[k];
            end
            else
            begin
                out_frame[k] = '0;
            end
        end
    end

    assign status       = status_reg;
    assign fill_frames  = mfrf_pkg::FILL_W'(fill);
    assign last_of_call = last_reg;

    // The store never sees a write and a read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("frame store written and read in the same cycle");

    // An accepted write advances the write pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (wp_reg != $past(wp_reg)))
        else $error("write pointer did not advance after a stored frame");

    // A clear returns both pointers to the first slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (func_reg == mfrf_pkg::FUNC_CLEAR)) |=> (wp_reg == '0) && (rp_reg == '0))
        else $error("clear left a pointer off slot zero");

    // An underrun is only reported while the FIFO is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.respond && (status_reg == mfrf_pkg::STATUS_UNDER)) |-> empty)
        else $error("underrun reported with frames held");

endmodule

`default_nettype wire

// ===== rtl/multichannel_frame_ring_fifo.sv =====
`default_nettype none

// Ring FIFO of audio frames, eight 32-bit sample words per frame, 1023 frames deep.
// A transaction is accepted when start is high and busy is low; its result appears
// on the output ports with done high for exactly one cycle, after its operands are
// captured and the frame store is accessed, and must be taken then since the receiver
// cannot stall the block. A transaction passes through capture, one access to the
// single-ported frame store and result, busy high until idle. The user must write
// channel_count via cfg_write_en and cfg_write_data only while idle (not enforced).
module multichannel_frame_ring_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] in_sample_0,
    input  wire logic [31:0] in_sample_1,
    input  wire logic [31:0] in_sample_2,
    input  wire logic [31:0] in_sample_3,
    input  wire logic [31:0] in_sample_4,
    input  wire logic [31:0] in_sample_5,
    input  wire logic [31:0] in_sample_6,
    input  wire logic [31:0] in_sample_7,
    input  wire logic        end_of_call,
    input  wire logic        cfg_write_en,
    input  wire logic [3:0]  cfg_write_data,
    output logic             done,
    output logic [31:0]      out_sample_0,
    output logic [31:0]      out_sample_1,
    output logic [31:0]      out_sample_2,
    output logic [31:0]      out_sample_3,
    output logic [31:0]      out_sample_4,
    output logic [31:0]      out_sample_5,
    output logic [31:0]      out_sample_6,
    output logic [31:0]      out_sample_7,
    output logic [1:0]       status,
    output logic [9:0]       fill_frames,
    output logic             last_of_call
);

    mfrf_pkg::cmd_t   cmd;
    mfrf_pkg::frame_t in_frame;
    mfrf_pkg::frame_t out_frame;

    // Gather the channel ports into one frame word.
    assign in_frame = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                       in_sample_3, in_sample_2, in_sample_1, in_sample_0};

    mfrf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mfrf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .func           (func),
        .in_frame       (in_frame),
        .end_of_call    (end_of_call),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_frame      (out_frame),
        .status         (status),
        .fill_frames    (fill_frames),
        .last_of_call   (last_of_call)
    );

    // Spread the result frame back onto the channel ports.
    assign out_sample_0 = out_frame[0];
    assign out_sample_1 = out_frame[1];
    assign out_sample_2 = out_frame[2];
    assign out_sample_3 = out_frame[3];
    assign out_sample_4 = out_frame[4];
    assign out_sample_5 = out_frame[5];
    assign out_sample_6 = out_frame[6];
    assign out_sample_7 = out_frame[7];

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // The block treats this code as a no-op.
    localparam logic [mfrf_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [mfrf_pkg::FUNC_W-1:0] func;
        mfrf_pkg::frame_t            frame;
        logic                        eoc;
    } fifo_op_t;

    typedef struct packed {
        mfrf_pkg::frame_t              frame;
        logic [mfrf_pkg::STATUS_W-1:0] status;
        logic [mfrf_pkg::FILL_W-1:0]   fill;
        logic                          last;
    } fifo_result_t;

    logic                          clk;
    logic                          rst_n          = 1'b0;
    logic                          start          = 1'b0;
    logic [mfrf_pkg::FUNC_W-1:0]   func_in        = FUNC_NOP;
    mfrf_pkg::frame_t              drv_frame      = '0;
    logic                          eoc_in         = 1'b0;
    logic                          cfg_write_en   = 1'b0;
    logic [mfrf_pkg::CHAN_W-1:0]   cfg_write_data = '0;
    logic                          busy;
    logic                          done;
    mfrf_pkg::frame_t              got_frame;
    logic [mfrf_pkg::STATUS_W-1:0] status;
    logic [mfrf_pkg::FILL_W-1:0]   fill_frames;
    logic                          last_of_call;

    // Stimulus and expectation stores.
    fifo_op_t     op_queue[$];
    fifo_result_t pending_results[$];
    int           items_queued = 0;
    int           items_taken  = 0;
    int           mismatches   = 0;
    int           stall_cycles = 0;
    logic         txn_taken    = 1'b0;
    logic         driving      = 1'b0;
    logic         drain_wait   = 1'b0;
    int           burst_left   = 1;
    int           gap_left     = 0;

    // Shadow copy of the FIFO state.
    mfrf_pkg::frame_t            frame_mem [mfrf_pkg::FRAMES];
    int                          wr_ptr   = 0;
    int                          rd_ptr   = 0;
    logic [mfrf_pkg::CHAN_W-1:0] chan_cfg = mfrf_pkg::CHAN_RESET;

    multichannel_frame_ring_fifo i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func_in),
        .in_sample_0    (drv_frame[0]),
        .in_sample_1    (drv_frame[1]),
        .in_sample_2    (drv_frame[2]),
        .in_sample_3    (drv_frame[3]),
        .in_sample_4    (drv_frame[4]),
        .in_sample_5    (drv_frame[5]),
        .in_sample_6    (drv_frame[6]),
        .in_sample_7    (drv_frame[7]),
        .end_of_call    (eoc_in),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .done           (done),
        .out_sample_0   (got_frame[0]),
        .out_sample_1   (got_frame[1]),
        .out_sample_2   (got_frame[2]),
        .out_sample_3   (got_frame[3]),
        .out_sample_4   (got_frame[4]),
        .out_sample_5   (got_frame[5]),
        .out_sample_6   (got_frame[6]),
        .out_sample_7   (got_frame[7]),
        .status         (status),
        .fill_frames    (fill_frames),
        .last_of_call   (last_of_call)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one operation to the shadow FIFO and returns the result it should give.
    function automatic fifo_result_t advance_fifo(
        input logic [mfrf_pkg::FUNC_W-1:0] op_func,
        input mfrf_pkg::frame_t            data,
        input logic                        eoc);
        fifo_result_t res;
        int           held;
        int           live;
        res        = '0;
        res.status = mfrf_pkg::STATUS_DONE;
        res.last   = eoc;
        held       = (wr_ptr + mfrf_pkg::FRAMES - rd_ptr) % mfrf_pkg::FRAMES;
        live       = (chan_cfg > mfrf_pkg::MAX_CHANNELS) ? mfrf_pkg::MAX_CHANNELS
                                                         : int'(chan_cfg);
        case (op_func)
            mfrf_pkg::FUNC_WRITE:
            begin
                if (held >= mfrf_pkg::FRAMES - 1)
                    res.status = mfrf_pkg::STATUS_FULL;
                else
                begin
                    frame_mem[wr_ptr] = data;
                    wr_ptr = (wr_ptr + 1) % mfrf_pkg::FRAMES;
                end
            end
            mfrf_pkg::FUNC_READ:
            begin
                if (held == 0)
                    res.status = mfrf_pkg::STATUS_UNDER;
                else
                begin
                    // Channels beyond the live count read as zero.
                    for (int ch = 0; ch < live; ch++)
                        res.frame[ch] = frame_mem[rd_ptr][ch];
                    rd_ptr = (rd_ptr + 1) % mfrf_pkg::FRAMES;
                end
            end
            mfrf_pkg::FUNC_CLEAR:
            begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            default:
            begin
            end
        endcase
        res.fill = mfrf_pkg::FILL_W'((wr_ptr + mfrf_pkg::FRAMES - rd_ptr) % mfrf_pkg::FRAMES);
        return res;
    endfunction

    function automatic mfrf_pkg::frame_t rand_frame();
        mfrf_pkg::frame_t f;
        for (int ch = 0; ch < mfrf_pkg::MAX_CHANNELS; ch++)
            f[ch] = $urandom();
        return f;
    endfunction

    function automatic void queue_op(input logic [mfrf_pkg::FUNC_W-1:0] op_func,
                                     input mfrf_pkg::frame_t data, input logic eoc);
        fifo_op_t op;
        op.func  = op_func;
        op.frame = data;
        op.eoc   = eoc;
        op_queue.push_back(op);
        items_queued++;
    endfunction

    // Queues a random mix of operations; whatever is left of the percentages is no-ops.
    function automatic void queue_mixed(input int count, input int wr_pct, input int rd_pct,
                                        input int clr_pct);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < wr_pct)
                queue_op(mfrf_pkg::FUNC_WRITE, rand_frame(), 1'($urandom_range(0, 1)));
            else if (pick < wr_pct + rd_pct)
                queue_op(mfrf_pkg::FUNC_READ, rand_frame(), 1'($urandom_range(0, 1)));
            else if (pick < wr_pct + rd_pct + clr_pct)
                queue_op(mfrf_pkg::FUNC_CLEAR, rand_frame(), 1'($urandom_range(0, 1)));
            else
                queue_op(FUNC_NOP, rand_frame(), 1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Returns once every queued transaction has been taken and answered.
    task automatic wait_idle();
        while (items_taken != items_queued || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Writes the channel count register while the block is idle.
    task automatic set_channels(input logic [mfrf_pkg::CHAN_W-1:0] count);
        wait_idle();
        repeat (4) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= count;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Driver: issues queued transactions in bursts separated by random gaps.
    always @(negedge clk)
    begin
        fifo_op_t op;
        int       pick;
        if (!driving || txn_taken)
        begin
            txn_taken = 1'b0;
            driving   = 1'b0;
            if (drain_wait && pending_results.size() != 0)
                start <= 1'b0;
            else if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (op_queue.size() == 0)
                start <= 1'b0;
            else
            begin
                drain_wait = 1'b0;
                op         = op_queue.pop_front();
                func_in   <= op.func;
                drv_frame <= op.frame;
                eoc_in    <= op.eoc;
                start     <= 1'b1;
                driving    = 1'b1;
                burst_left--;
                // At the end of a burst pick the next gap: none, short, or a full drain.
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    pick       = $urandom_range(0, 15);
                    if (pick < 5)
                        gap_left = 0;
                    else if (pick == 15)
                        drain_wait = 1'b1;
                    else
                        gap_left = $urandom_range(1, 7);
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expectation and predicts new ones.
    always @(posedge clk)
    begin
        fifo_result_t want;
        if (cfg_write_en)
            chan_cfg = cfg_write_data;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                want = pending_results.pop_front();
                for (int ch = 0; ch < mfrf_pkg::MAX_CHANNELS; ch++)
                    if (got_frame[ch] !== want.frame[ch])
                        report_mismatch($sformatf("out_sample_%0d got %h expected %h",
                                                  ch, got_frame[ch], want.frame[ch]));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              status, want.status));
                if (fill_frames !== want.fill)
                    report_mismatch($sformatf("fill_frames got %0d expected %0d",
                                              fill_frames, want.fill));
                if (last_of_call !== want.last)
                    report_mismatch($sformatf("last_of_call got %b expected %b",
                                              last_of_call, want.last));
            end
        end
        if (rst_n && start && !busy)
        begin
            pending_results.push_back(advance_fifo(func_in, drv_frame, eoc_in));
            items_taken++;
            txn_taken = 1'b1;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("multichannel_frame_ring_fifo verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        int fill_writes;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed checks at the reset channel count: underrun, no-op, extreme words.
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b1);
        queue_op(FUNC_NOP, rand_frame(), 1'b0);
        queue_op(mfrf_pkg::FUNC_WRITE, '1, 1'b1);
        queue_op(mfrf_pkg::FUNC_WRITE, '0, 1'b0);
        queue_op(mfrf_pkg::FUNC_WRITE, {4{32'hAAAA_AAAA, 32'h5555_5555}}, 1'b1);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b0);
        queue_op(mfrf_pkg::FUNC_READ, '1, 1'b1);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b0);
        queue_op(mfrf_pkg::FUNC_READ, '1, 1'b1);
        // Clear drops held frames, so the read after it underruns.
        queue_op(mfrf_pkg::FUNC_WRITE, rand_frame(), 1'b0);
        queue_op(mfrf_pkg::FUNC_WRITE, rand_frame(), 1'b1);
        queue_op(mfrf_pkg::FUNC_CLEAR, rand_frame(), 1'b1);
        queue_op(mfrf_pkg::FUNC_READ, rand_frame(), 1'b0);

        // All channels live; then a frame written at eight channels is read at zero.
        set_channels(4'd8);
        queue_op(mfrf_pkg::FUNC_WRITE, '1, 1'b0);
        queue_op(mfrf_pkg::FUNC_WRITE, {4{32'h5555_5555, 32'hAAAA_AAAA}}, 1'b1);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b1);
        set_channels(4'd0);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b0);
        // A count above the channel total saturates.
        set_channels(4'd15);
        queue_op(mfrf_pkg::FUNC_WRITE, rand_frame(), 1'b0);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b1);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b0);
        set_channels(4'd1);
        queue_op(mfrf_pkg::FUNC_WRITE, rand_frame(), 1'b1);
        queue_op(mfrf_pkg::FUNC_READ, '0, 1'b0);

        // Random mixes at several channel counts.
        set_channels(4'd3);
        queue_mixed(60, 50, 40, 3);
        set_channels(4'd8);
        queue_mixed(60, 30, 60, 3);
        set_channels(4'd0);
        queue_mixed(30, 50, 40, 3);
        set_channels(4'd15);
        queue_mixed(40, 60, 30, 3);

        // Fill to capacity and try a few writes beyond it.
        set_channels(4'($urandom_range(1, 8)));
        queue_op(mfrf_pkg::FUNC_CLEAR, rand_frame(), 1'b0);
        fill_writes = 0;
        while (fill_writes < mfrf_pkg::FRAMES + 2)
        begin
            if ($urandom_range(0, 49) == 0)
                queue_op(FUNC_NOP, rand_frame(), 1'($urandom_range(0, 1)));
            else
            begin
                queue_op(mfrf_pkg::FUNC_WRITE, rand_frame(), 1'($urandom_range(0, 1)));
                fill_writes++;
            end
        end

        // Drain part of it, then write on so the write pointer wraps around.
        set_channels(4'($urandom_range(0, 15)));
        queue_mixed(150, 10, 85, 0);
        set_channels(4'($urandom_range(0, 15)));
        queue_mixed(120, 70, 25, 0);
        set_channels(4'd2);
        queue_mixed(40, 45, 45, 5);

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("multichannel_frame_ring_fifo verification clean");
        else
            $display("multichannel_frame_ring_fifo verification failed");
        $finish;
    end

endmodule
